>>> sv/fship_pkg.sv
// ----------------------------------------------------------------------------
// fship_pkg: shared types and constants for the format string printer
// Character codes and the control bundle of the BCD shift unit.
// ----------------------------------------------------------------------------
package fship_pkg;

    // ASCII codes
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_D        = 8'h64;
    localparam logic [7:0] CH_X        = 8'h78;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    // 'a' - 10, so that digit 10 maps to 'a'
    localparam logic [7:0] CH_HEX_BASE = 8'h57;

    // BCD digit register control
    typedef struct packed {
        logic clear;        // zero all digits
        logic shift_bit;    // double-dabble step, bit_in enters at the bottom
        logic bit_in;
        logic shift_digit;  // drop the top digit, zero enters at the bottom
    } t_bcd_ctl;

endpackage

>>> sv/fship_bcd.sv
// ----------------------------------------------------------------------------
// fship_bcd: bit-serial binary to BCD converter
// Double-dabble register: one binary bit per step, then the digits are
// shifted out from the top one at a time.
// ----------------------------------------------------------------------------
module fship_bcd #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                i_clk,
    input  fship_pkg::t_bcd_ctl i_ctl,
    output logic [3:0]          o_top_digit
);

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] n_bcd;
    logic [BCD_W-1:0] w_adj;

    // add-3 correction on every digit that is 5 or more
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // next digit register value
    always_comb begin
        n_bcd = r_bcd;
        if (i_ctl.clear) begin
            n_bcd = '0;
        end else if (i_ctl.shift_bit) begin
            n_bcd = {w_adj[BCD_W-2:0], i_ctl.bit_in};
        end else if (i_ctl.shift_digit) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

>>> sv/format_string_int_hex_printer.sv
// ----------------------------------------------------------------------------
// format_string_int_hex_printer: printf-style character formatter
// Echoes format bytes and expands %%, %d (signed decimal) and %x (hex); other bytes after % are dropped.
// ----------------------------------------------------------------------------
// An echoed byte or %% passes through ST_CHAR and then the output register.
// %d: ARG_WIDTH magnitude bits are shifted into the BCD register, then leading
//   zero digits are skipped and one beat goes out per character (sign, digits).
// %x: (ARG_WIDTH+3)/4 nibbles, leading zero nibbles skipped, one beat per printed one.
// One item at a time: the decimal converter and the digit emitter set the pace.
// Reset (i_rst_n low, synchronous) clears the pending '%', the state and tvalid.
module format_string_int_hex_printer #(
    parameter int ARG_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beat
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] fmt_byte, [39:8] arg_word
    // output beat
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast    // run_last
);

    localparam int NUM_DIGITS = (ARG_WIDTH * 31) / 100 + 1;
    localparam int NUM_NIBS   = (ARG_WIDTH + 3) / 4;
    localparam int BIN_W      = 4 * NUM_NIBS;
    localparam int PAD_W      = BIN_W - ARG_WIDTH;
    localparam int CNT_W      = $clog2(ARG_WIDTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHAR   = 6'b000010,
        ST_DABBLE = 6'b000100,
        ST_SIGN   = 6'b001000,
        ST_DEC    = 6'b010000,
        ST_HEX    = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic               r_pending, n_pending;
    logic               r_neg, n_neg;
    logic               r_seen, n_seen;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BIN_W-1:0]   r_bin, n_bin;
    logic [7:0]         r_char, n_char;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_char, n_out_char;
    logic               r_out_last, n_out_last;

    logic [7:0]           w_fmt;
    logic [BIN_W+31:0]    w_arg_ext;
    logic [ARG_WIDTH-1:0] w_val;
    logic [ARG_WIDTH-1:0] w_mag;
    logic                 w_in_acc;
    logic                 w_out_ok;
    logic                 w_last_cnt;
    logic [3:0]           w_dec_digit;
    logic [3:0]           w_hex_digit;
    fship_pkg::t_bcd_ctl  w_bcd_ctl;

    // field unpack and argument at ARG_WIDTH bits
    assign w_fmt     = s_axis_tdata[7:0];
    assign w_arg_ext = {{BIN_W{1'b0}}, s_axis_tdata[39:8]};
    assign w_val     = w_arg_ext[ARG_WIDTH-1:0];
    assign w_mag     = w_val[ARG_WIDTH-1] ? (~w_val + 1'b1) : w_val;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_ok      = !r_out_valid || m_axis_tready;
    assign w_last_cnt    = (r_cnt == CNT_W'(1));
    assign w_hex_digit   = r_bin[BIN_W-1 -: 4];

    fship_bcd #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd (
        .i_clk       (i_clk),
        .i_ctl       (w_bcd_ctl),
        .o_top_digit (w_dec_digit)
    );

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_cnt       = r_cnt;
        n_bin       = r_bin;
        n_char      = r_char;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_bcd_ctl   = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (r_pending) begin
                        n_pending = 1'b0;
                        if (w_fmt == fship_pkg::CH_PERCENT) begin
                            n_char  = fship_pkg::CH_PERCENT;
                            n_state = ST_CHAR;
                        end else if (w_fmt == fship_pkg::CH_D) begin
                            n_neg           = w_val[ARG_WIDTH-1];
                            n_bin           = BIN_W'(w_mag) << PAD_W;
                            n_cnt           = CNT_W'(ARG_WIDTH);
                            w_bcd_ctl.clear = 1'b1;
                            n_state         = ST_DABBLE;
                        end else if (w_fmt == fship_pkg::CH_X) begin
                            n_bin   = BIN_W'(w_val);
                            n_cnt   = CNT_W'(NUM_NIBS);
                            n_seen  = 1'b0;
                            n_state = ST_HEX;
                        end
                    end else if (w_fmt == fship_pkg::CH_PERCENT) begin
                        n_pending = 1'b1;
                    end else begin
                        n_char  = w_fmt;
                        n_state = ST_CHAR;
                    end
                end
            end
            ST_CHAR: begin
                if (w_out_ok) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_char;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_DABBLE: begin
                // one magnitude bit into the BCD register per cycle
                w_bcd_ctl.shift_bit = 1'b1;
                w_bcd_ctl.bit_in    = r_bin[BIN_W-1];
                n_bin               = r_bin << 1;
                n_cnt               = r_cnt - 1'b1;
                if (w_last_cnt) begin
                    n_cnt   = CNT_W'(NUM_DIGITS);
                    n_seen  = 1'b0;
                    n_state = r_neg ? ST_SIGN : ST_DEC;
                end
            end
            ST_SIGN: begin
                if (w_out_ok) begin
                    n_out_valid = 1'b1;
                    n_out_char  = fship_pkg::CH_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = ST_DEC;
                end
            end
            ST_DEC: begin
                // leading zeros are dropped, the units digit always prints
                if (w_dec_digit == 4'd0 && !r_seen && !w_last_cnt) begin
                    w_bcd_ctl.shift_digit = 1'b1;
                    n_cnt                 = r_cnt - 1'b1;
                end else if (w_out_ok) begin
                    n_out_valid           = 1'b1;
                    n_out_char            = fship_pkg::CH_ZERO + {4'b0000, w_dec_digit};
                    n_out_last            = w_last_cnt;
                    n_seen                = 1'b1;
                    w_bcd_ctl.shift_digit = 1'b1;
                    n_cnt                 = r_cnt - 1'b1;
                    if (w_last_cnt) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_HEX: begin
                if (w_hex_digit == 4'd0 && !r_seen && !w_last_cnt) begin
                    n_bin = {r_bin[BIN_W-5:0], 4'b0000};
                    n_cnt = r_cnt - 1'b1;
                end else if (w_out_ok) begin
                    n_out_valid = 1'b1;
                    if (w_hex_digit <= 4'd9) begin
                        n_out_char = fship_pkg::CH_ZERO + {4'b0000, w_hex_digit};
                    end else begin
                        n_out_char = fship_pkg::CH_HEX_BASE + {4'b0000, w_hex_digit};
                    end
                    n_out_last = w_last_cnt;
                    n_seen     = 1'b1;
                    n_bin      = {r_bin[BIN_W-5:0], 4'b0000};
                    n_cnt      = r_cnt - 1'b1;
                    if (w_last_cnt) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_seen     <= n_seen;
        r_cnt      <= n_cnt;
        r_bin      <= n_bin;
        r_char     <= n_char;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> sv/fship_chk.sv
// ----------------------------------------------------------------------------
// fship_chk: port checker for the format string printer
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module fship_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // no input is taken while a run of characters is still being produced
    a_busy_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a character run");

    // after a minus sign the output holds nothing yet or a digit
    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast &&
        m_axis_tdata == fship_pkg::CH_MINUS |=>
            !m_axis_tvalid ||
            (m_axis_tdata >= fship_pkg::CH_ZERO &&
             m_axis_tdata <= fship_pkg::CH_ZERO + 8'd9))
        else $error("sign not followed by digits");

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind format_string_int_hex_printer fship_chk u_fship_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/fship_char_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fship_char_check: output checker for the format string printer
// Watches both stream channels. Every accepted format beat is expanded into
// the characters it should print, which wait in order until the output side
// delivers them. Each output beat is compared against the oldest one.
// ----------------------------------------------------------------------------
module fship_char_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] fmt_byte, [39:8] arg_word
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] out_char
    input  logic        m_axis_tlast,   // run_last
    output int          o_fail_count,
    output int          o_pending,
    output int          o_char_count
);

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
    } t_char_beat;

    // characters still owed by the block, oldest first
    t_char_beat expected_chars[$];
    logic       pct_armed = 1'b0;
    int         fails     = 0;
    int         n_chars   = 0;

    // Expand one format beat into the characters it prints
    function automatic void format_expected(input logic [7:0] fmt, input logic [31:0] arg);
        t_char_beat  run[$];
        logic [31:0] mag;
        logic [3:0]  digs[$];
        logic [3:0]  nib;
        logic [7:0]  hex_chr;
        logic        started;
        started = 1'b0;
        if (pct_armed) begin
            pct_armed = 1'b0;
            if (fmt == fship_pkg::CH_PERCENT) begin
                run.push_back('{chr: fship_pkg::CH_PERCENT, last: 1'b0});
            end else if (fmt == fship_pkg::CH_D) begin
                // sign first, then the unsigned magnitude; min value negates to itself
                mag = arg;
                if (arg[31]) begin
                    run.push_back('{chr: fship_pkg::CH_MINUS, last: 1'b0});
                    mag = ~arg + 32'd1;
                end
                do begin
                    digs.push_front(4'(mag % 32'd10));
                    mag = mag / 32'd10;
                end while (mag != 32'd0);
                foreach (digs[i])
                    run.push_back('{chr: fship_pkg::CH_ZERO + {4'h0, digs[i]}, last: 1'b0});
            end else if (fmt == fship_pkg::CH_X) begin
                // skip leading zero nibbles, but always print the last one
                for (int i = 7; i >= 0; i--) begin
                    nib = arg[i*4 +: 4];
                    if (started || nib != 4'h0 || i == 0) begin
                        started = 1'b1;
                        if (nib <= 4'd9)
                            hex_chr = fship_pkg::CH_ZERO + {4'h0, nib};
                        else
                            hex_chr = fship_pkg::CH_HEX_BASE + {4'h0, nib};
                        run.push_back('{chr: hex_chr, last: 1'b0});
                    end
                end
            end
        end else if (fmt == fship_pkg::CH_PERCENT) begin
            pct_armed = 1'b1;
        end else begin
            run.push_back('{chr: fmt, last: 1'b0});
        end
        if (run.size() > 0) begin
            run[run.size()-1].last = 1'b1;
            foreach (run[i])
                expected_chars.push_back(run[i]);
        end
    endfunction

    // Compare output beats first: an input beat in the same cycle is always newer
    always @(posedge i_clk) begin : watch
        t_char_beat want;
        if (!i_rst_n) begin
            expected_chars.delete();
            pct_armed = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_chars++;
                if (expected_chars.size() == 0) begin
                    $error("out beat with nothing expected: out_char=%h run_last=%b",
                           m_axis_tdata, m_axis_tlast);
                    fails++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.chr) begin
                        $error("out_char: expected %h actual %h", want.chr, m_axis_tdata);
                        fails++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("run_last: expected %b actual %b", want.last, m_axis_tlast);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                format_expected(s_axis_tdata[7:0], s_axis_tdata[39:8]);
        end
        o_fail_count <= fails;
        o_pending    <= expected_chars.size();
        o_char_count <= n_chars;
    end

endmodule

>>> tb/format_string_int_hex_printer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_string_int_hex_printer_tb: stimulus and verdict for the printer
// Sends directed format beats (echo, %%, %d and %x extremes, dropped
// selectors), then random mostly well-formed sequences with random gaps on
// both sides, one long output stall and one drain pause. Checking is done
// by fship_char_check.
// ----------------------------------------------------------------------------
module format_string_int_hex_printer_tb;

    localparam int IDLE_LIMIT  = 2000;   // cycles without any beat
    localparam int TOTAL_ITEMS = 270;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int char_count;

    // knobs shared by stimulus and receiver
    logic tx_quiet = 1'b0;
    logic rx_quiet = 1'b0;
    logic hold_req = 1'b0;

    // tallies for the summary
    logic shadow_armed = 1'b0;
    int   n_items   = 0;
    int   n_echo    = 0;
    int   n_dec     = 0;
    int   n_hex     = 0;
    int   n_pct     = 0;
    int   n_dropped = 0;

    format_string_int_hex_printer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    fship_char_check u_char_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_char_count  (char_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Argument words weighted toward the interesting corners
    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(0, 20);
            6: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h0000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h8000_0000;
                    3:       return 32'h8000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            7:       return 32'd0 - $urandom_range(1, 1000);
            8:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom_range(0, 15) << (4 * $urandom_range(0, 7));
        endcase
    endfunction

    // Receiver: random ready, quiet stretches, and one long hold on request
    initial begin
        int r;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_quiet) begin
                m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_axis_tready <= 1'b1;
                end else if (r < 97) begin
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(negedge i_clk);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat for %0d cycles, %0d characters still owed",
                 IDLE_LIMIT, pending);
        $display("FAIL");
        $finish;
    end

    // One input beat: optional gap, offer, wait for acceptance. Starts and ends
    // just after a falling edge, so tvalid gets one assignment per step.
    task automatic send_item(input logic [7:0] fmt, input logic [31:0] arg);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, 8'($urandom_range(0, 255))};
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {arg, fmt};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        // classify for the summary
        n_items++;
        if (shadow_armed) begin
            shadow_armed = 1'b0;
            case (fmt)
                fship_pkg::CH_PERCENT: n_pct++;
                fship_pkg::CH_D:       n_dec++;
                fship_pkg::CH_X:       n_hex++;
                default:               n_dropped++;
            endcase
        end else if (fmt == fship_pkg::CH_PERCENT) begin
            shadow_armed = 1'b1;
        end else begin
            n_echo++;
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [7:0] fmt;
        int         k;
        logic       hold_done;
        logic       pause_done;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: echoes incl. NUL and 0xFF, literal percent
        send_item("A", 32'h0);
        send_item(8'h00, 32'hFFFF_FFFF);
        send_item(8'hFF, 32'h0);
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_PERCENT, 32'h1234_5678);
        // decimal: zero, max, min, minus one, the single digit nine
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_D, 32'h0000_0000);
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_D, 32'h7FFF_FFFF);
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_D, 32'h8000_0000);
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_D, 32'hFFFF_FFFF);
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_D, 32'd9);
        // hex: zero, all ones, a lone letter digit
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_X, 32'h0000_0000);
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_X, 32'hFFFF_FFFF);
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(fship_pkg::CH_X, 32'd10);
        // dropped selectors: unsupported string conversion and NUL after percent
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item("s", 32'hDEAD_BEEF);
        send_item(fship_pkg::CH_PERCENT, 32'h0);
        send_item(8'h00, 32'h0);

        // random: mostly well-formed conversions, some noise
        while (n_items < TOTAL_ITEMS) begin
            tx_quiet = (n_items >= 70 && n_items < 110);
            rx_quiet = (n_items >= 80 && n_items < 120);
            if (!hold_done && n_items >= 140) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && n_items >= 200) begin
                s_axis_tvalid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                @(negedge i_clk);
                pause_done = 1'b1;
            end
            k = $urandom_range(0, 99);
            if (k < 35) begin
                do fmt = 8'($urandom_range(0, 255)); while (fmt == fship_pkg::CH_PERCENT);
                send_item(fmt, $urandom);
            end else if (k < 60) begin
                send_item(fship_pkg::CH_PERCENT, $urandom);
                send_item(fship_pkg::CH_D, pick_arg());
            end else if (k < 82) begin
                send_item(fship_pkg::CH_PERCENT, $urandom);
                send_item(fship_pkg::CH_X, pick_arg());
            end else if (k < 88) begin
                send_item(fship_pkg::CH_PERCENT, $urandom);
                send_item(fship_pkg::CH_PERCENT, $urandom);
            end else if (k < 94) begin
                do fmt = 8'($urandom_range(0, 255));
                while (fmt == fship_pkg::CH_PERCENT || fmt == fship_pkg::CH_D ||
                       fmt == fship_pkg::CH_X);
                send_item(fship_pkg::CH_PERCENT, $urandom);
                send_item(fmt, pick_arg());
            end else begin
                // stray byte, often a percent that swallows the next beat
                fmt = $urandom_range(0, 1) ? fship_pkg::CH_PERCENT
                                           : 8'($urandom_range(0, 255));
                send_item(fmt, pick_arg());
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        // drain, then allow for a late stray beat
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("covered %0d format beats: %0d echoed, %0d %%d, %0d %%x, %0d %%%%, %0d dropped",
                 n_items, n_echo, n_dec, n_hex, n_pct, n_dropped);
        $display("checked %0d output characters, %0d mismatches", char_count, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
